// ----- hdl/falb_pkg.sv -----
// Package for the flow affinity least-load balancer.
// Types, sizes and command/status structs shared by controller, datapath and top.
// No dependencies.
package falb_pkg;

   localparam int unsigned SERVERS    = 16;
   localparam int unsigned FLOWS      = 256;
   localparam int unsigned SRV_W      = $clog2(SERVERS);
   localparam int unsigned FLOW_W     = $clog2(FLOWS);
   localparam int unsigned FLOW_CNT_W = $clog2(FLOWS + 1);
   localparam int unsigned SLOT_W     = 4;
   localparam logic [31:0] LOAD_INF   = 32'hffffffff;

   localparam logic ACTION_LOOKUP = 1'b0;
   localparam logic ACTION_WRITE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [7:0]  protocol_number;
      logic [3:0]  slot_select;
      logic [31:0] slot_address;
   } req_type;

   typedef struct packed {
      logic [3:0]  server_index;
      logic [31:0] server_address;
      logic        new_flow;
      logic        flow_recorded;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;       // latch request beat
      logic do_write;       // server slot write
      logic flow_clear;     // reset flow scan index
      logic flow_read;      // issue table read at scan index
      logic flow_check;     // compare registered read data, advance index on no match
      logic srv_clear;      // reset server scan
      logic srv_load;       // start divide for current server
      logic div_step;       // one restoring divide step
      logic srv_finish;     // compare quotient, advance server
      logic do_hit;         // commit hit
      logic do_miss;        // commit miss
      logic send;           // strobe result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_write;
      logic hit;            // match seen in last check
      logic flow_last;      // entry being checked is the last stored flow
      logic srv_end;        // server scan done
      logic div_done;
   } sts_type;

endpackage

// ----- hdl/falb_ctrl.sv -----
// Controller state machine for the flow affinity least-load balancer.
// Depends on falb_pkg (cmd_type, sts_type).
module falb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  falb_pkg::sts_type sts,
   output falb_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_FREAD, ST_FWAIT, ST_FCHECK,
      ST_SNEXT, ST_DIV, ST_SFIN, ST_COMMIT, ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      miss_ff, miss_in;

   always_comb begin
      state_in = state_ff;
      miss_in  = miss_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_write) begin
               cmd.do_write = 1'b1;
               state_in     = ST_SEND;
            end else begin
               cmd.flow_clear = 1'b1;
               state_in       = ST_FREAD;
            end
         end
         ST_FREAD: begin
            cmd.flow_read = 1'b1;
            state_in      = ST_FWAIT;
         end
         ST_FWAIT: state_in = ST_FCHECK;
         ST_FCHECK: begin
            cmd.flow_check = 1'b1;
            if (sts.hit) begin
               miss_in  = 1'b0;
               state_in = ST_COMMIT;
            end else if (sts.flow_last) begin
               cmd.srv_clear = 1'b1;
               miss_in       = 1'b1;
               state_in      = ST_SNEXT;
            end else begin
               state_in = ST_FREAD;
            end
         end
         ST_SNEXT: begin
            if (sts.srv_end) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.srv_load = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.div_done) begin
               state_in = ST_SFIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SFIN: begin
            cmd.srv_finish = 1'b1;
            state_in       = ST_SNEXT;
         end
         ST_COMMIT: begin
            cmd.do_hit  = !miss_ff;
            cmd.do_miss = miss_ff;
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            cmd.send = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         miss_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         miss_ff  <= miss_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      cmd.send |=> !cmd.send)
      else $error("result strobed twice");
   a_hit_miss_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_hit && cmd.do_miss))
      else $error("hit and miss commit together");
   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

endmodule

// ----- hdl/falb_dp.sv -----
// Datapath: server tables, flow table memory, restoring divider, scan registers.
// Depends on falb_pkg.
module falb_dp (
   input  logic              clock,
   input  logic              reset,
   input  falb_pkg::req_type req,
   input  falb_pkg::cmd_type cmd,
   output falb_pkg::sts_type sts,
   output logic              rsp_strobe,
   output falb_pkg::rsp_type rsp
);

   localparam int unsigned SRV_W  = falb_pkg::SRV_W;
   localparam int unsigned FLOW_W = falb_pkg::FLOW_W;
   localparam int unsigned FCW    = falb_pkg::FLOW_CNT_W;
   localparam int unsigned SCW    = $clog2(falb_pkg::SERVERS + 1);

   falb_pkg::req_type req_ff;

   // server state, valid at reset through clearing
   logic [31:0] addr_ff [falb_pkg::SERVERS];
   logic [31:0] fcnt_ff [falb_pkg::SERVERS];
   logic [31:0] pcnt_ff [falb_pkg::SERVERS];

   // flow table memory
   logic [63:0]      mem_a [falb_pkg::FLOWS];
   logic [39:0]      mem_p [falb_pkg::FLOWS];
   logic [SRV_W-1:0] mem_s [falb_pkg::FLOWS];
   logic [63:0]      rd_a_ff;
   logic [39:0]      rd_p_ff;
   logic [SRV_W-1:0] rd_s_ff;
   logic [FCW-1:0]   fill_ff;      // entries are filled in order, never freed

   logic [FCW-1:0]   fix_ff;
   logic             hit_ff;
   logic [SRV_W-1:0] hit_srv_ff;

   logic [SCW-1:0]   six_ff;
   logic [SRV_W-1:0] best_ff;
   logic [31:0]      low_load_ff;

   logic [31:0] quo_ff, rem_ff, dsr_ff;
   logic [5:0]  dcnt_ff;
   logic        zero_div_ff;

   // room at miss commit: the new flow was stored
   logic        room_was_ff;

   logic [63:0]      key_a;
   logic [39:0]      key_p;
   logic [SRV_W-1:0] six;
   logic [32:0]      trial;
   logic [31:0]      load;
   logic             room;
   logic [SRV_W-1:0] pick;

   assign key_a = {req_ff.source_address, req_ff.destination_address};
   assign key_p = {req_ff.source_port, req_ff.destination_port, req_ff.protocol_number};
   assign six   = six_ff[SRV_W-1:0];
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
   assign load  = zero_div_ff ? 32'd0 : quo_ff;
   assign room  = (fill_ff < FCW'(falb_pkg::FLOWS));
   assign pick  = best_ff;

   assign sts.is_write  = (req_ff.action == falb_pkg::ACTION_WRITE);
   assign sts.hit       = (fix_ff < fill_ff) && (rd_a_ff == key_a) && (rd_p_ff == key_p);
   assign sts.flow_last = (fix_ff + FCW'(1)) >= fill_ff;
   assign sts.srv_end   = (six_ff == SCW'(falb_pkg::SERVERS)) || (addr_ff[six] == 32'd0);
   assign sts.div_done  = zero_div_ff || (dcnt_ff == 6'd32);

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req;
      if (cmd.flow_read) begin
         rd_a_ff <= mem_a[fix_ff[FLOW_W-1:0]];
         rd_p_ff <= mem_p[fix_ff[FLOW_W-1:0]];
         rd_s_ff <= mem_s[fix_ff[FLOW_W-1:0]];
      end
      if (cmd.do_miss && room) begin
         mem_a[fill_ff[FLOW_W-1:0]] <= key_a;
         mem_p[fill_ff[FLOW_W-1:0]] <= key_p;
         mem_s[fill_ff[FLOW_W-1:0]] <= pick;
      end
      if (cmd.srv_load) begin
         quo_ff      <= pcnt_ff[six];
         dsr_ff      <= fcnt_ff[six];
         rem_ff      <= '0;
         dcnt_ff     <= '0;
         zero_div_ff <= (fcnt_ff[six] == 32'd0);
      end else if (cmd.div_step) begin
         if (!trial[32]) rem_ff <= trial[31:0];
         else            rem_ff <= {rem_ff[30:0], quo_ff[31]};
         quo_ff  <= {quo_ff[30:0], !trial[32]};
         dcnt_ff <= dcnt_ff + 6'd1;
      end
      if (cmd.flow_check && sts.hit) hit_srv_ff <= rd_s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < falb_pkg::SERVERS; i++) begin
            addr_ff[i] <= '0;
            fcnt_ff[i] <= '0;
            pcnt_ff[i] <= '0;
         end
         fill_ff     <= '0;
         fix_ff      <= '0;
         hit_ff      <= 1'b0;
         six_ff      <= '0;
         best_ff     <= '0;
         low_load_ff <= falb_pkg::LOAD_INF;
         rsp_strobe  <= 1'b0;
      end else begin
         rsp_strobe <= cmd.send;
         if (cmd.do_write) begin
            hit_ff <= 1'b0;
            if (SCW'(req_ff.slot_select) < SCW'(falb_pkg::SERVERS)) begin
               addr_ff[req_ff.slot_select[SRV_W-1:0]] <= req_ff.slot_address;
               fcnt_ff[req_ff.slot_select[SRV_W-1:0]] <= '0;
               pcnt_ff[req_ff.slot_select[SRV_W-1:0]] <= '0;
            end
         end
         if (cmd.flow_clear) begin
            fix_ff <= '0;
            hit_ff <= 1'b0;
         end
         if (cmd.flow_check) begin
            if (sts.hit) hit_ff <= 1'b1;
            else         fix_ff <= fix_ff + FCW'(1);
         end
         if (cmd.srv_clear) begin
            six_ff      <= '0;
            best_ff     <= '0;
            low_load_ff <= falb_pkg::LOAD_INF;
         end
         if (cmd.srv_finish) begin
            if (load < low_load_ff) begin
               best_ff     <= six;
               low_load_ff <= load;
            end
            six_ff <= six_ff + SCW'(1);
         end
         if (cmd.do_hit) pcnt_ff[hit_srv_ff] <= pcnt_ff[hit_srv_ff] + 32'd1;
         if (cmd.do_miss) begin
            pcnt_ff[pick] <= pcnt_ff[pick] + 32'd1;
            fcnt_ff[pick] <= fcnt_ff[pick] + 32'd1;
            if (room) fill_ff <= fill_ff + FCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         if (req_ff.action == falb_pkg::ACTION_WRITE) begin
            rsp.server_index   <= req_ff.slot_select;
            rsp.server_address <= (SCW'(req_ff.slot_select) < SCW'(falb_pkg::SERVERS))
                                  ? req_ff.slot_address : 32'd0;
            rsp.new_flow       <= 1'b0;
            rsp.flow_recorded  <= 1'b0;
         end else if (hit_ff) begin
            rsp.server_index   <= falb_pkg::SLOT_W'(hit_srv_ff);
            rsp.server_address <= addr_ff[hit_srv_ff];
            rsp.new_flow       <= 1'b0;
            rsp.flow_recorded  <= 1'b0;
         end else begin
            rsp.server_index   <= falb_pkg::SLOT_W'(pick);
            rsp.server_address <= addr_ff[pick];
            rsp.new_flow       <= 1'b1;
            rsp.flow_recorded  <= room_was_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_miss) room_was_ff <= room;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FCW'(falb_pkg::FLOWS))
      else $error("flow fill count overran table");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> dcnt_ff < 6'd32)
      else $error("divider ran past 32 steps");
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.do_miss |=> $stable(fill_ff))
      else $error("fill count moved outside a miss");

endmodule

// ----- hdl/flow_affinity_least_load_balancer_top.sv -----
// Top level of the flow affinity least-load balancer.
// A write answers at once; a lookup scans stored flows up to a match at entry k, and a
// miss scans all F stored flows, then S servers (at most 256 flows, 16 servers). One beat
// in flight; busy falls as rsp_strobe rises, rsp cannot stall. Flow scan paced by the
// table's registered read, server scan by the 32-step restoring divider. Sync reset
// clears counters, fill, FSM.
module flow_affinity_least_load_balancer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  falb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output falb_pkg::rsp_type rsp_data
);

   falb_pkg::cmd_type cmd;
   falb_pkg::sts_type sts;

   // controller sequences lookup, divide scan and commit
   falb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath holds all tables and the divider
   falb_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the flow affinity least-load balancer top.
// Drives request beats through start/busy, predicts each response in-line and
// compares it with rsp_data on rsp_strobe. Depends on falb_pkg and the top RTL.
`timescale 1ns / 100ps

module testbench;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   falb_pkg::req_type req_data;
   logic              rsp_strobe;
   falb_pkg::rsp_type rsp_data;

   flow_affinity_least_load_balancer_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // predictor state
   logic [31:0] srv_addr [falb_pkg::SERVERS];
   logic [31:0] srv_flows [falb_pkg::SERVERS];
   logic [31:0] srv_pkts [falb_pkg::SERVERS];
   logic        flow_used [falb_pkg::FLOWS];
   logic [63:0] flow_addrs [falb_pkg::FLOWS];
   logic [39:0] flow_ports [falb_pkg::FLOWS];
   logic [3:0]  flow_srv [falb_pkg::FLOWS];

   falb_pkg::rsp_type pending_rsp[$];
   int          mismatches;
   int          rsp_seen;
   int          n_hits, n_new, n_full, n_writes;
   longint      cycles;

   // directed rows: beat plus optional typed-in answer
   typedef struct {
      falb_pkg::req_type beat;
      bit                has_exp;
      falb_pkg::rsp_type exp_rsp;
   } row_type;
   row_type dir_rows[$];

   // remembered flow keys (up to 400) so random traffic produces hits
   falb_pkg::req_type known_flows[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   function automatic falb_pkg::rsp_type balance_predict(falb_pkg::req_type b);
      falb_pkg::rsp_type r;
      int      free_ix;
      logic [31:0] low_load, load;
      int      best;
      r = '0;
      if (b.action == falb_pkg::ACTION_WRITE) begin
         srv_addr[b.slot_select]  = b.slot_address;
         srv_flows[b.slot_select] = 0;
         srv_pkts[b.slot_select]  = 0;
         r.server_index   = b.slot_select;
         r.server_address = b.slot_address;
         n_writes++;
         return r;
      end
      free_ix = -1;
      for (int i = 0; i < falb_pkg::FLOWS; i++) begin
         if (flow_used[i]) begin
            if (flow_addrs[i] == {b.source_address, b.destination_address} &&
                flow_ports[i] == {b.source_port, b.destination_port,
                                  b.protocol_number}) begin
               srv_pkts[flow_srv[i]] += 1;
               r.server_index   = flow_srv[i];
               r.server_address = srv_addr[flow_srv[i]];
               n_hits++;
               return r;
            end
         end else if (free_ix < 0) begin
            free_ix = i;
         end
      end
      best = 0;
      low_load = falb_pkg::LOAD_INF;
      for (int s = 0; s < falb_pkg::SERVERS; s++) begin
         if (srv_addr[s] == 0) break;
         load = (srv_flows[s] == 0) ? 32'd0 : srv_pkts[s] / srv_flows[s];
         if (load < low_load) begin
            best = s;
            low_load = load;
         end
      end
      srv_pkts[best]  += 1;
      srv_flows[best] += 1;
      r.server_index   = best[3:0];
      r.server_address = srv_addr[best];
      r.new_flow       = 1'b1;
      n_new++;
      if (free_ix >= 0) begin
         flow_used[free_ix]  = 1'b1;
         flow_addrs[free_ix] = {b.source_address, b.destination_address};
         flow_ports[free_ix] = {b.source_port, b.destination_port, b.protocol_number};
         flow_srv[free_ix]   = best[3:0];
         r.flow_recorded     = 1'b1;
      end else begin
         n_full++;
      end
      return r;
   endfunction

   // response checker: strobe is a single-cycle beat, never held off
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         rsp_seen <= rsp_seen + 1;
         if (pending_rsp.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("unexpected response %p", rsp_data);
         end else begin
            falb_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (e !== rsp_data) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch exp %0d %h %b %b got %0d %h %b %b",
                     e.server_index, e.server_address, e.new_flow, e.flow_recorded,
                     rsp_data.server_index, rsp_data.server_address, rsp_data.new_flow,
                     rsp_data.flow_recorded);
            end
         end
      end
   end

   // send one beat; the prediction (or typed answer) is queued once busy falls;
   // start stays high into the next beat when no idle cycles are drawn
   task automatic send_beat(falb_pkg::req_type b, bit has_exp, falb_pkg::rsp_type exp_rsp);
      falb_pkg::rsp_type p;
      int                idle;
      idle = $urandom_range(0, 9);
      if (idle != 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = balance_predict(b);
      if (has_exp && p !== exp_rsp) begin
         mismatches++;
         if (mismatches <= 10) $display("directed answer disagrees with predictor %p", p);
      end
      pending_rsp.push_back(p);
   endtask

   function automatic falb_pkg::req_type lookup_beat(logic [31:0] sa, logic [31:0] da,
                                                     logic [15:0] sp, logic [15:0] dp,
                                                     logic [7:0] pr);
      falb_pkg::req_type b;
      b = '0;
      b.action = falb_pkg::ACTION_LOOKUP;
      b.source_address = sa; b.destination_address = da;
      b.source_port = sp; b.destination_port = dp; b.protocol_number = pr;
      b.slot_select = 4'($urandom); b.slot_address = $urandom;
      return b;
   endfunction

   function automatic falb_pkg::req_type write_beat(logic [3:0] slot, logic [31:0] a);
      falb_pkg::req_type b;
      b = '0;
      b.action = falb_pkg::ACTION_WRITE;
      b.source_address = $urandom; b.destination_address = $urandom;
      b.source_port = 16'($urandom); b.destination_port = 16'($urandom);
      b.protocol_number = 8'($urandom);
      b.slot_select = slot; b.slot_address = a;
      return b;
   endfunction

   function automatic falb_pkg::rsp_type mk_rsp(logic [3:0] i, logic [31:0] a, logic n,
                                                logic r);
      falb_pkg::rsp_type x;
      x.server_index = i; x.server_address = a; x.new_flow = n; x.flow_recorded = r;
      return x;
   endfunction

   function automatic void add_row(falb_pkg::req_type b, bit has, falb_pkg::rsp_type e);
      row_type r;
      r.beat = b; r.has_exp = has; r.exp_rsp = e;
      dir_rows.push_back(r);
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      falb_pkg::req_type b;
      int      pick;
      for (int s = 0; s < falb_pkg::SERVERS; s++) begin
         srv_addr[s] = 0; srv_flows[s] = 0; srv_pkts[s] = 0;
      end
      for (int i = 0; i < falb_pkg::FLOWS; i++) begin
         flow_used[i] = 0; flow_addrs[i] = 0; flow_ports[i] = 0; flow_srv[i] = 0;
      end
      mismatches = 0; rsp_seen = 0; cycles = 0;
      n_hits = 0; n_new = 0; n_full = 0; n_writes = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no servers -> slot 0, extremes of the key, writes, hits
      add_row(lookup_beat(0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 1, 1));
      add_row(lookup_beat(0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0));
      add_row(lookup_beat('1, '1, '1, '1, '1), 1, mk_rsp(0, 0, 1, 1));
      add_row(write_beat(0, 32'h0a000001), 1, mk_rsp(0, 32'h0a000001, 0, 0));
      add_row(write_beat(1, 32'h0a000002), 1, mk_rsp(1, 32'h0a000002, 0, 0));
      add_row(write_beat(15, 32'hffffffff), 1, mk_rsp(15, 32'hffffffff, 0, 0));
      add_row(lookup_beat(0, 0, 0, 0, 0), 1, mk_rsp(0, 32'h0a000001, 0, 0));
      add_row(lookup_beat(1, 2, 3, 4, 17), 0, '0);
      add_row(lookup_beat(5, 6, 7, 8, 17), 0, '0);
      add_row(lookup_beat(1, 2, 3, 4, 17), 0, '0);
      add_row(lookup_beat(1, 2, 3, 4, 6), 0, '0);
      add_row(write_beat(2, 32'h0a000003), 1, mk_rsp(2, 32'h0a000003, 0, 0));
      add_row(lookup_beat(32'h80000000, 1, 16'h8000, 1, 8'h80), 0, '0);
      // rewrite slot 0 after flows are assigned: flows stay, address follows
      add_row(write_beat(0, 32'hc0a80001), 1, mk_rsp(0, 32'hc0a80001, 0, 0));
      add_row(lookup_beat(0, 0, 0, 0, 0), 0, '0);
      add_row(lookup_beat('1, '1, '1, '1, '1), 0, '0);
      add_row(write_beat(3, 0), 1, mk_rsp(3, 0, 0, 0));
      add_row(lookup_beat(9, 9, 9, 9, 9), 0, '0);
      foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].has_exp, dir_rows[k].exp_rsp);

      // pressure point: pause until every response is back
      wait_drained();

      // random: mostly lookups, reuse of known keys, occasional slot writes;
      // 1000+ lookups overflow the 256-entry table, exercising the full case
      for (int n = 0; n < 1100; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            b = write_beat(4'($urandom), ($urandom_range(0, 7) == 0) ? 32'd0 :
                           (($urandom_range(0, 7) == 0) ? 32'hffffffff : $urandom));
         end else if (pick < 50 && known_flows.size() > 0) begin
            b = known_flows[$urandom_range(0, known_flows.size() - 1)];
            b.slot_select = 4'($urandom); b.slot_address = $urandom;
         end else begin
            b = lookup_beat($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
            if (known_flows.size() < 400) known_flows.push_back(b);
         end
         send_beat(b, 0, '0);
         if (n == 550) wait_drained();
      end
      wait_drained();
   end

   // end of run: drain, settle, report
   initial begin
      @(negedge reset);
      while (rsp_seen < 1118 && cycles < 64'd8000000) @(posedge clock);
      if (cycles >= 64'd8000000) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         repeat (50) @(posedge clock);
         $display("covered %0d lookups that hit, %0d new flows (%0d with table full), %0d writes",
            n_hits, n_new, n_full, n_writes);
         if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("end of test: clean");
         end else begin
            $display("end of test: mismatches");
         end
         $finish;
      end
   end

endmodule
